[src/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the periodic task timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam logic [31:0] FOREVER   = 32'hFFFF_FFFF;
  localparam logic [31:0] EMPTY_DUE = 32'h00FF_FFFF;
  localparam int          RES_MAX   = 16;
  localparam int          RW        = $clog2(RES_MAX + 1);
  localparam int          RIW       = $clog2(RES_MAX);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_BAD_ARGS = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REMOVED  = 3'd3;
  localparam logic [2:0] ST_NOT_FND  = 3'd4;
  localparam logic [2:0] ST_FIRED    = 3'd5;
  localparam logic [2:0] ST_NO_FIRE  = 3'd6;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_DEL,
    OP_TICK,
    OP_FIRE
  } op_kind_t;

  typedef enum logic [1:0] {
    SCAN_FREE,
    SCAN_MATCH,
    SCAN_FIRE,
    SCAN_DUE
  } scan_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] new_id;
    logic [31:0] period;
    logic [31:0] count;
    logic [31:0] elapsed;
    logic [31:0] tid;
  } cell_op_t;

  typedef struct packed {
    logic        found;
    logic [31:0] key;
  } link_t;

endpackage

[src/ptt_cell.sv]
// ----------------------------------------------------------------------------
// ptt_cell
// One timer slot. Applies broadcast updates and forwards the running search
// result to its neighbor every cycle.
// ----------------------------------------------------------------------------
module ptt_cell #(
  parameter int SLOTS = 16,
  parameter int IDX   = 0,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptt_pkg::cell_op_t op,
  input  logic [SW-1:0]    op_slot,
  input  ptt_pkg::scan_t   mode,
  input  ptt_pkg::link_t   link_in,
  input  logic [SW-1:0]    slot_in,
  output ptt_pkg::link_t   link_out,
  output logic [SW-1:0]    slot_out
);
  import ptt_pkg::*;

  localparam logic [SW-1:0] MY_SLOT = SW'(IDX);

  logic        valid_r, valid_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] period_r, period_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] wait_r, wait_nxt;
  link_t       link_r, link_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  logic        sel;
  logic        cand;
  logic        take;
  logic [31:0] key_mine;
  logic [31:0] rem_dec;

  assign sel = (op_slot == MY_SLOT);

  always_comb begin
    valid_nxt  = valid_r;
    id_nxt     = id_r;
    period_nxt = period_r;
    rem_nxt    = rem_r;
    wait_nxt   = wait_r;
    rem_dec    = (rem_r != 32'd0) ? rem_r - 32'd1 : 32'd0;
    case (op.kind)
      OP_ADD: begin
        if (sel) begin
          valid_nxt  = 1'b1;
          id_nxt     = op.new_id;
          period_nxt = op.period;
          rem_nxt    = op.count;
          wait_nxt   = op.period;
        end
      end
      OP_DEL: begin
        if (sel) valid_nxt = 1'b0;
      end
      OP_TICK: begin
        if (valid_r) wait_nxt = (wait_r > op.elapsed) ? wait_r - op.elapsed : 32'd0;
      end
      OP_FIRE: begin
        if (sel) begin
          wait_nxt = period_r;
          if (rem_r != FOREVER) begin
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) valid_nxt = 1'b0;
          end
          if (period_r == 32'd0) valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cand     = 1'b0;
    key_mine = 32'd0;
    take     = 1'b0;
    case (mode)
      SCAN_FREE: begin
        cand = !valid_r;
        take = cand && !link_in.found;
      end
      SCAN_MATCH: begin
        cand = valid_r && (id_r == op.tid);
        take = cand && !link_in.found;
      end
      SCAN_FIRE: begin
        cand     = valid_r && (wait_r == 32'd0);
        key_mine = id_r;
        take     = cand && (!link_in.found || (key_mine < link_in.key));
      end
      default: begin
        cand     = valid_r;
        key_mine = wait_r;
        take     = cand && (!link_in.found || (key_mine < link_in.key));
      end
    endcase
    if (take) begin
      link_nxt.found = 1'b1;
      link_nxt.key   = key_mine;
      slot_nxt       = MY_SLOT;
    end else begin
      link_nxt = link_in;
      slot_nxt = slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      link_r  <= '0;
      slot_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      link_r  <= link_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    period_r <= period_nxt;
    rem_r    <= rem_nxt;
    wait_r   <= wait_nxt;
  end

  assign link_out = link_r;
  assign slot_out = slot_r;

endmodule

[src/periodic_task_timer_table.sv]
// ----------------------------------------------------------------------------
// periodic_task_timer_table
// Table of periodic timers built as a chain of slot cells with a controller.
// ----------------------------------------------------------------------------
// Each search pass walks the whole cell chain.
// Add/remove: a slot pass, then a next-due pass, then the emit state; a rejected
//   add or the unused command skips the slot pass.
// Tick: the tick state, fire passes until none is due or the result buffer is full, then the next-due pass and emits.
// Each result is registered out in the cycle after its emit cycle; the next transfer may be
//   accepted once busy drops. Synchronous reset empties the table, id counter = 1.
module periodic_task_timer_table #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_period_ms,
  input  logic [31:0] in_repeat_count,
  input  logic [31:0] in_task_id,
  input  logic [31:0] in_elapsed_ms,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_id,
  output logic [31:0] out_next_due_ms,
  output logic        out_last
);
  import ptt_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 2);

  state_t      state_r, state_nxt;
  scan_t       mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] period_r, count_r, tid_r, elapsed_r;
  logic [31:0] next_id_r, next_id_nxt;
  logic [RW-1:0] n_r, n_nxt, n_base;
  logic [RIW-1:0] rd_r, rd_nxt;
  logic [31:0] due_r, due_nxt;
  logic [2:0]  stat_buf [RES_MAX];
  logic [31:0] id_buf [RES_MAX];

  logic        push_en;
  logic [2:0]  push_st;
  logic [31:0] push_id;
  logic        accept;
  logic        emit_last;

  logic        out_strobe_r, out_last_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_id_r;

  cell_op_t    op;
  logic [SW-1:0] op_slot;
  link_t       link_w [SLOTS+1];
  logic [SW-1:0] slot_w [SLOTS+1];
  link_t       res;
  logic [SW-1:0] res_slot;
  logic        scan_done;

  assign link_w[0] = '0;
  assign slot_w[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ptt_cell #(.SLOTS(SLOTS), .IDX(g), .SW(SW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .op_slot (op_slot),
      .mode    (mode_r),
      .link_in (link_w[g]),
      .slot_in (slot_w[g]),
      .link_out(link_w[g+1]),
      .slot_out(slot_w[g+1])
    );
  end

  assign res       = link_w[SLOTS];
  assign res_slot  = slot_w[SLOTS];
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign scan_done = (state_r == S_SCAN) && (cnt_r == CW'(SLOTS));
  assign n_base    = (state_r == S_IDLE) ? '0 : n_r;
  assign emit_last = (RW'(rd_r) + RW'(1) == n_r);

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    cnt_nxt     = (state_r == S_SCAN) ? cnt_r + CW'(1) : cnt_r;
    next_id_nxt = next_id_r;
    n_nxt       = n_r;
    rd_nxt      = rd_r;
    due_nxt     = due_r;
    push_en     = 1'b0;
    push_st     = ST_BAD_ARGS;
    push_id     = 32'd0;
    op.kind     = OP_NONE;
    op.new_id   = next_id_r;
    op.period   = period_r;
    op.count    = count_r;
    op.elapsed  = elapsed_r;
    op.tid      = tid_r;
    op_slot     = res_slot;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
          n_nxt     = '0;
          unique case (cmd_t'(in_command))
            CMD_ADD: begin
              if (in_period_ms == 32'd0 || in_repeat_count == 32'd0) begin
                push_en  = 1'b1;
                mode_nxt = SCAN_DUE;
              end else begin
                mode_nxt = SCAN_FREE;
              end
            end
            CMD_REMOVE: mode_nxt = SCAN_MATCH;
            CMD_TICK:   state_nxt = S_TICK;
            default: begin
              push_en  = 1'b1;
              mode_nxt = SCAN_DUE;
            end
          endcase
        end
      end
      S_TICK: begin
        op.kind   = OP_TICK;
        state_nxt = S_SCAN;
        mode_nxt  = SCAN_FIRE;
        cnt_nxt   = '0;
      end
      S_SCAN: begin
        if (scan_done) begin
          cnt_nxt  = '0;
          mode_nxt = SCAN_DUE;
          unique case (mode_r)
            SCAN_FREE: begin
              push_en = 1'b1;
              if (res.found) begin
                op.kind     = OP_ADD;
                push_st     = ST_ADDED;
                push_id     = next_id_r;
                next_id_nxt = next_id_r + 32'd1;
              end else begin
                push_st = ST_FULL;
              end
            end
            SCAN_MATCH: begin
              push_en = 1'b1;
              push_id = tid_r;
              if (res.found) begin
                op.kind = OP_DEL;
                push_st = ST_REMOVED;
              end else begin
                push_st = ST_NOT_FND;
              end
            end
            SCAN_FIRE: begin
              if (res.found && n_r < RW'(RES_MAX)) begin
                op.kind  = OP_FIRE;
                push_en  = 1'b1;
                push_st  = ST_FIRED;
                push_id  = res.key;
                mode_nxt = SCAN_FIRE;
              end else if (n_r == '0) begin
                push_en = 1'b1;
                push_st = ST_NO_FIRE;
              end
            end
            default: begin
              due_nxt   = res.found ? res.key : EMPTY_DUE;
              state_nxt = S_EMIT;
              rd_nxt    = '0;
            end
          endcase
        end
      end
      default: begin
        rd_nxt = rd_r + RIW'(1);
        if (emit_last) state_nxt = S_IDLE;
      end
    endcase
    if (push_en) n_nxt = n_base + RW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= SCAN_DUE;
      cnt_r        <= '0;
      next_id_r    <= 32'd1;
      n_r          <= '0;
      rd_r         <= '0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      cnt_r        <= cnt_nxt;
      next_id_r    <= next_id_nxt;
      n_r          <= n_nxt;
      rd_r         <= rd_nxt;
      out_strobe_r <= (state_r == S_EMIT);
      out_last_r   <= (state_r == S_EMIT) && emit_last;
    end
  end

  always_ff @(posedge clk) begin
    due_r <= due_nxt;
    if (accept) begin
      period_r  <= in_period_ms;
      count_r   <= in_repeat_count;
      tid_r     <= in_task_id;
      elapsed_r <= in_elapsed_ms;
    end
    if (push_en) begin
      stat_buf[n_base[RIW-1:0]] <= push_st;
      id_buf[n_base[RIW-1:0]]   <= push_id;
    end
    out_status_r <= stat_buf[rd_r];
    out_id_r     <= id_buf[rd_r];
  end

  assign out_strobe      = out_strobe_r;
  assign out_last        = out_last_r;
  assign out_status      = out_status_r;
  assign out_result_id   = out_id_r;
  assign out_next_due_ms = due_r;

  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe) else $error("last without strobe");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("not busy after transfer");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe) else $error("result burst broken");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RW'(RES_MAX)) else $error("result buffer overflow");

endmodule

[tb/tb_periodic_task_timer_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_timer_table
// Self-checking bench for the periodic task timer table. A directed table
// covers bad arguments, a full table, remove hit and miss, ticks with and
// without firings, infinite repeats and the unused command. Random add,
// remove and tick traffic follows. Every result is checked against a
// behavioral model of the table.
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_table;
  import ptt_pkg::*;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [31:0] due;
    logic        last;
  } timer_rsp_t;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] period;
    logic [31:0] count;
    logic [31:0] tid;
    logic [31:0] elapsed;
    logic        known;
    logic [2:0]  exp_status;
    logic [31:0] exp_id;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_period_ms;
  logic [31:0] in_repeat_count;
  logic [31:0] in_task_id;
  logic [31:0] in_elapsed_ms;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [31:0] out_result_id;
  logic [31:0] out_next_due_ms;
  logic        out_last;

  periodic_task_timer_table #(.SLOTS(NSLOT)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_period_ms(in_period_ms),
    .in_repeat_count(in_repeat_count), .in_task_id(in_task_id),
    .in_elapsed_ms(in_elapsed_ms), .out_strobe(out_strobe),
    .out_status(out_status), .out_result_id(out_result_id),
    .out_next_due_ms(out_next_due_ms), .out_last(out_last)
  );

  logic        m_valid [NSLOT];
  logic [31:0] m_id    [NSLOT];
  logic [31:0] m_period[NSLOT];
  logic [31:0] m_left  [NSLOT];
  logic [31:0] m_wait  [NSLOT];
  logic [31:0] m_next_id;

  timer_rsp_t pending_rsp[$];
  int         errors;
  int         n_items;
  int         n_fired;
  int         n_results;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("periodic_task_timer_table regression: fail");
    $finish;
  end

  function automatic logic [31:0] table_next_due();
    logic [31:0] best;
    logic        any;
    best = 32'd0;
    any = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (m_valid[i] && (!any || m_wait[i] < best)) begin
        best = m_wait[i];
        any = 1'b1;
      end
    end
    return any ? best : EMPTY_DUE;
  endfunction

  task automatic apply_command(input cmd_t cmd, input logic [31:0] period,
                               input logic [31:0] count, input logic [31:0] tid,
                               input logic [31:0] elapsed);
    timer_rsp_t step_rsp[$];
    timer_rsp_t r;
    logic [31:0] due;
    int slot;
    int pick;
    slot = -1;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        if (period == 0 || count == 0) begin
          r.status = ST_BAD_ARGS;
          step_rsp.push_back(r);
        end else begin
          for (int i = NSLOT - 1; i >= 0; i--) if (!m_valid[i]) slot = i;
          if (slot < 0) begin
            r.status = ST_FULL;
            step_rsp.push_back(r);
          end else begin
            m_valid[slot] = 1'b1;
            m_id[slot] = m_next_id;
            m_period[slot] = period;
            m_left[slot] = count;
            m_wait[slot] = period;
            r.status = ST_ADDED;
            r.id = m_next_id;
            step_rsp.push_back(r);
            m_next_id = m_next_id + 32'd1;
          end
        end
      end
      CMD_REMOVE: begin
        for (int i = NSLOT - 1; i >= 0; i--) if (m_valid[i] && m_id[i] == tid) slot = i;
        if (slot >= 0) m_valid[slot] = 1'b0;
        r.status = (slot >= 0) ? ST_REMOVED : ST_NOT_FND;
        r.id = tid;
        step_rsp.push_back(r);
      end
      CMD_TICK: begin
        for (int i = 0; i < NSLOT; i++)
          if (m_valid[i]) m_wait[i] = (m_wait[i] > elapsed) ? m_wait[i] - elapsed : 32'd0;
        while (step_rsp.size() < RES_MAX) begin
          pick = -1;
          for (int i = 0; i < NSLOT; i++)
            if (m_valid[i] && m_wait[i] == 0 && (pick < 0 || m_id[i] < m_id[pick]))
              pick = i;
          if (pick < 0) break;
          r.status = ST_FIRED;
          r.id = m_id[pick];
          step_rsp.push_back(r);
          n_fired++;
          m_wait[pick] = m_period[pick];
          if (m_left[pick] != FOREVER) begin
            if (m_left[pick] != 0) m_left[pick] = m_left[pick] - 32'd1;
            if (m_left[pick] == 0) m_valid[pick] = 1'b0;
          end
          if (m_wait[pick] == 0) m_valid[pick] = 1'b0;
        end
        if (step_rsp.size() == 0) begin
          r.status = ST_NO_FIRE;
          r.id = 32'd0;
          step_rsp.push_back(r);
        end
      end
      default: begin
        r.status = ST_BAD_ARGS;
        step_rsp.push_back(r);
      end
    endcase
    due = table_next_due();
    foreach (step_rsp[k]) begin
      step_rsp[k].due = due;
      step_rsp[k].last = (k == step_rsp.size() - 1);
      pending_rsp.push_back(step_rsp[k]);
    end
  endtask

  always @(posedge clk) begin
    timer_rsp_t e;
    if (rst_n && out_strobe) begin
      n_results++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%0h", $time, out_status,
                 out_result_id);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_result_id !== e.id) begin
          $display("%0t: result_id exp %0h got %0h", $time, e.id, out_result_id);
          errors++;
        end
        if (out_next_due_ms !== e.due) begin
          $display("%0t: next_due exp %0h got %0h", $time, e.due, out_next_due_ms);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last exp %0b got %0b", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // One transfer: hold start until accepted, then update the model.
  task automatic send(input cmd_t cmd, input logic [31:0] period,
                      input logic [31:0] count, input logic [31:0] tid,
                      input logic [31:0] elapsed, input bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_period_ms <= period;
    in_repeat_count <= count;
    in_task_id <= tid;
    in_elapsed_ms <= elapsed;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_command(cmd, period, count, tid, elapsed);
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_small();
    return $urandom_range(1, 60);
  endfunction

  dir_row_t dir_rows[$];

  task automatic add_row(input cmd_t c, input logic [31:0] p, input logic [31:0] n,
                         input logic [31:0] t, input logic [31:0] el, input logic k,
                         input logic [2:0] s, input logic [31:0] id);
    dir_row_t row;
    row.cmd = c; row.period = p; row.count = n; row.tid = t; row.elapsed = el;
    row.known = k; row.exp_status = s; row.exp_id = id;
    dir_rows.push_back(row);
  endtask

  initial begin
    cmd_t        c;
    logic [31:0] p;
    logic [31:0] n;
    logic [31:0] t;
    logic [31:0] el;
    int          live_ids[$];
    int          pick;
    bit          idle_ok;
    errors = 0; n_items = 0; n_fired = 0; n_results = 0;
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 1'b0; m_id[i] = '0; m_period[i] = '0; m_left[i] = '0; m_wait[i] = '0;
    end
    m_next_id = 32'd1;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ADD;
    in_period_ms = '0;
    in_repeat_count = '0;
    in_task_id = '0;
    in_elapsed_ms = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(CMD_TICK,   0, 0, 0, 32'd5, 1, ST_NO_FIRE, 0);
    add_row(CMD_REMOVE, 0, 0, 32'hFFFF_FFFF, 0, 1, ST_NOT_FND, 32'hFFFF_FFFF);
    add_row(CMD_ADD,    0, 32'd3, 0, 0, 1, ST_BAD_ARGS, 0);
    add_row(CMD_ADD,    32'd5, 0, 0, 0, 1, ST_BAD_ARGS, 0);
    add_row(CMD_RSVD,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1, ST_BAD_ARGS, 0);
    add_row(CMD_ADD,    32'd3, 32'd2, 0, 0, 1, ST_ADDED, 32'd1);
    add_row(CMD_ADD,    32'd3, FOREVER, 0, 0, 1, ST_ADDED, 32'd2);
    add_row(CMD_ADD,    32'hFFFF_FFFF, 32'd1, 0, 0, 1, ST_ADDED, 32'd3);
    add_row(CMD_TICK,   0, 0, 0, 32'd0, 0, 0, 0);
    add_row(CMD_TICK,   0, 0, 0, 32'd3, 0, 0, 0);
    add_row(CMD_TICK,   0, 0, 0, 32'd2, 0, 0, 0);
    add_row(CMD_TICK,   0, 0, 0, 32'd1, 0, 0, 0);
    add_row(CMD_REMOVE, 0, 0, 32'd2, 0, 1, ST_REMOVED, 32'd2);
    add_row(CMD_REMOVE, 0, 0, 32'd2, 0, 1, ST_NOT_FND, 32'd2);
    for (int i = 0; i < NSLOT; i++) add_row(CMD_ADD, 32'd7, 32'd1, 0, 0, 0, 0, 0);
    add_row(CMD_TICK,   0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].cmd, dir_rows[i].period, dir_rows[i].count, dir_rows[i].tid,
           dir_rows[i].elapsed, 1'b1);
      if (dir_rows[i].known &&
          (pending_rsp[$].status !== dir_rows[i].exp_status ||
           pending_rsp[$].id !== dir_rows[i].exp_id)) begin
        $display("%0t: table row %0d exp status %0d id %0h, model %0d %0h", $time, i,
                 dir_rows[i].exp_status, dir_rows[i].exp_id, pending_rsp[$].status,
                 pending_rsp[$].id);
        errors++;
      end
    end
    drain();

    for (int k = 0; k < 100; k++) begin
      idle_ok = (k < 75);
      if (k == 50) drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          c = CMD_ADD;
          p = ($urandom_range(0, 9) == 0) ? $urandom() : rand_small();
          n = ($urandom_range(0, 3) == 0) ? FOREVER : $urandom_range(1, 4);
          if ($urandom_range(0, 19) == 0) p = 0;
          if ($urandom_range(0, 19) == 0) n = $urandom();
          if ($urandom_range(0, 19) == 0) n = 0;
        end
        4, 5: begin
          c = CMD_REMOVE;
          live_ids.delete();
          for (int i = 0; i < NSLOT; i++) if (m_valid[i]) live_ids.push_back(m_id[i]);
          if (live_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, live_ids.size() - 1);
            t = live_ids[pick];
          end else t = $urandom();
        end
        9: begin
          c = ($urandom_range(0, 1) == 0) ? CMD_RSVD : CMD_TICK;
          el = $urandom();
        end
        default: begin
          c = CMD_TICK;
          el = $urandom_range(0, 30);
        end
      endcase
      send(c, p, n, t, el, idle_ok);
      p = $urandom(); n = $urandom(); t = $urandom(); el = (c == CMD_TICK) ? el : $urandom();
    end
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d commands, %0d results, %0d timer firings.", n_items, n_results,
             n_fired);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("periodic_task_timer_table regression: pass");
    end else begin
      $display("periodic_task_timer_table regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ptt_pkg.sv
src/ptt_cell.sv
src/periodic_task_timer_table.sv
tb/tb_periodic_task_timer_table.sv
